// File: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the pose block; empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property, switched off while reset is asserted.
`define RPCI_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked property that is checked in reset as well.
`define RPCI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RPCI_ASSERT(lbl, clk, rstn, prop, msg)
`define RPCI_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: hw/rtl/rpci_pkg.sv
// ---------------------------------------------------------------------------
// rpci_pkg
// Types, fixed-point constants and helper functions of the rigid pose block.
// ---------------------------------------------------------------------------
package rpci_pkg;

    // Quaternions are signed Q2.29; translations carry 16 fraction bits.
    localparam int QUAT_FRAC_BITS   = 29;
    localparam int RSQRT_ITERATIONS = 3;

    // Shared multiplier operand and product widths.
    localparam int MUL_W  = 35;
    localparam int PROD_W = 2 * MUL_W;

    typedef logic signed [MUL_W-1:0]  mul_op_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    // Action codes.
    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_COMPOSE = 2'd1;
    localparam logic [1:0] ACT_INVERT  = 2'd2;
    localparam logic [1:0] ACT_HOLD    = 2'd3;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] in_qw;
        logic signed [31:0] in_qx;
        logic signed [31:0] in_qy;
        logic signed [31:0] in_qz;
        logic signed [31:0] in_tx;
        logic signed [31:0] in_ty;
        logic signed [31:0] in_tz;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] out_qw;
        logic signed [31:0] out_qx;
        logic signed [31:0] out_qy;
        logic signed [31:0] out_qz;
        logic signed [31:0] out_tx;
        logic signed [31:0] out_ty;
        logic signed [31:0] out_tz;
        logic               saturated;
    } out_word_t;

    typedef struct packed {
        logic               clip;
        logic signed [31:0] val;
    } sat_t;

    localparam prod_t S32_MAX = prod_t'(2147483647);
    localparam prod_t S32_MIN = -S32_MAX - prod_t'(1);

    // Saturate a wide signed value to 32 bits and flag clipping.
    function automatic sat_t sat32(input prod_t v);
        sat_t s;
        s.clip = 1'b0;
        s.val  = 32'(v);
        if (v > S32_MAX) begin
            s.clip = 1'b1;
            s.val  = 32'(S32_MAX);
        end else if (v < S32_MIN) begin
            s.clip = 1'b1;
            s.val  = 32'(S32_MIN);
        end
        return s;
    endfunction

    // Q16 start values for the inverse square root, indexed by n/2^58 - 4.
    function automatic logic [15:0] rsqrt_seed(input logic [3:0] idx);
        logic [15:0] v;
        case (idx)
            4'd0:    v = 16'd61788;
            4'd1:    v = 16'd55889;
            4'd2:    v = 16'd51411;
            4'd3:    v = 16'd47861;
            4'd4:    v = 16'd44957;
            4'd5:    v = 16'd42525;
            4'd6:    v = 16'd40450;
            4'd7:    v = 16'd38651;
            4'd8:    v = 16'd37073;
            4'd9:    v = 16'd35673;
            4'd10:   v = 16'd34421;
            4'd11:   v = 16'd33292;
            default: v = 16'd32768;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/rpci_mul.sv
// ---------------------------------------------------------------------------
// rpci_mul
// Shared signed multiplier with a registered product.
// ---------------------------------------------------------------------------
module rpci_mul (
    input  logic             aclk,
    input  rpci_pkg::mul_op_t op_a,
    input  rpci_pkg::mul_op_t op_b,
    output rpci_pkg::prod_t   prod
);
    import rpci_pkg::*;

    prod_t prod_reg;

    // One product per cycle, available the cycle after its operands.
    always_ff @(posedge aclk) begin
        prod_reg <= prod_t'(op_a) * prod_t'(op_b);
    end

    assign prod = prod_reg;

endmodule

// File: hw/rtl/rigid_pose_compose_invert.sv
// ---------------------------------------------------------------------------
// rigid_pose_compose_invert
// Stored rigid pose with load, compose and invert, renormalized after each.
// ---------------------------------------------------------------------------
// The block holds one pose (Q2.29 quaternion, Q16.16 translation) and returns
// the updated pose as one word for every input word. All products go through
// one 35x35 multiplier under a sequencer, and the block takes no new word
// until the current one is finished. A compose runs the products, matrix,
// rotation, translation update, Hamilton product and renormalization; an
// invert skips the Hamilton product, a load starts at the renormalization and
// the unused action code at the result; zero quaternions skip the square root.
// A finished result waits in an output register while the next word is taken.
`include "assert_macros.svh"

module rigid_pose_compose_invert (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rpci_pkg::in_word_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rpci_pkg::out_word_t  m_data
);
    import rpci_pkg::*;

    // Sequencer phases.
    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_QQ    = 4'd1;
    localparam logic [3:0] PH_MAT   = 4'd2;
    localparam logic [3:0] PH_ROT   = 4'd3;
    localparam logic [3:0] PH_TUP   = 4'd4;
    localparam logic [3:0] PH_HAM   = 4'd5;
    localparam logic [3:0] PH_AMAX  = 4'd6;
    localparam logic [3:0] PH_LEN   = 4'd7;
    localparam logic [3:0] PH_SCALE = 4'd8;
    localparam logic [3:0] PH_NSUM  = 4'd9;
    localparam logic [3:0] PH_DBL   = 4'd10;
    localparam logic [3:0] PH_NEWT  = 4'd11;
    localparam logic [3:0] PH_OUT   = 4'd12;
    localparam logic [3:0] PH_DONE  = 4'd13;

    localparam int QM_W  = 36;
    localparam int ENT_W = 33;
    localparam int R_W   = 38;
    localparam int MAG_W = 63;
    localparam int LEN_W = 6;
    localparam int Y_W   = 34;
    localparam int OUT_SHIFT = 60 - QUAT_FRAC_BITS;

    localparam prod_t RND_Q   = prod_t'(1) <<< (QUAT_FRAC_BITS - 1);
    localparam prod_t RND_OUT = prod_t'(1) <<< (OUT_SHIFT - 1);
    localparam logic [Y_W-1:0] THREE_Q30 = Y_W'(3) << 30;
    localparam logic signed [31:0] ONE_Q = 32'(1) <<< QUAT_FRAC_BITS;
    localparam logic signed [39:0] ONE_E = 40'(1) <<< QUAT_FRAC_BITS;
    localparam logic signed [39:0] ENT_LIM = 40'(1) <<< 31;

    logic [3:0]  ph_reg;
    logic [4:0]  idx_reg;
    logic [2:0]  iter_reg;
    logic [1:0]  act_reg;
    in_word_t    in_reg;
    logic signed [31:0]      pq_reg [4];
    logic signed [31:0]      pt_reg [3];
    logic signed [QM_W-1:0]  qm_reg [9];
    logic signed [ENT_W-1:0] ent_reg [9];
    logic signed [ENT_W-1:0] ent_next [9];
    logic signed [R_W-1:0]   r_reg [3];
    logic signed [63:0]      c_reg [4];
    logic [MAG_W-1:0]        amax_reg;
    logic [LEN_W-1:0]        len_reg;
    logic signed [31:0]      m_reg [4];
    logic [63:0]             n_reg;
    logic [Y_W-1:0]          y_reg;
    logic [Y_W-1:0]          t_reg;
    logic [31:0]             h_reg;
    logic                    clip_reg;
    logic                    m_valid_reg;
    out_word_t               m_data_reg;

    mul_op_t op_a;
    mul_op_t op_b;
    prod_t   prod;
    prod_t   rq_q;
    prod_t   rq_o;
    logic    s_fire;
    logic [3:0] kk;
    logic signed [31:0] iq [4];
    logic signed [31:0] tv [3];
    logic [1:0] ham_a;
    logic [1:0] ham_b;
    logic       ham_neg;
    logic [1:0] rot_col;
    logic [1:0] rot_row;
    logic [3:0] rot_e;
    logic signed [39:0] mat [9];
    logic       tr;
    sat_t       tup_s [3];
    logic signed [63:0] cur_c;
    logic [MAG_W-1:0]   mag;
    logic [LEN_W-1:0]   len_base;
    logic [LEN_W-1:0]   len_cand;
    logic               len_hit;
    logic signed [31:0] sc_m;
    logic               n_small;
    logic [63:0]        nn;
    logic [3:0]         seed_idx;
    logic [Y_W-1:0]     xyy;
    sat_t               out_s;

    assign s_ready = (ph_reg == PH_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign kk      = idx_reg[3:0] - 4'd1;
    assign tr      = (act_reg == ACT_INVERT);

    assign iq[0] = in_reg.in_qw;
    assign iq[1] = in_reg.in_qx;
    assign iq[2] = in_reg.in_qy;
    assign iq[3] = in_reg.in_qz;

    // Compose rotates the incoming translation; invert rotates the stored one.
    assign tv[0] = tr ? pt_reg[0] : in_reg.in_tx;
    assign tv[1] = tr ? pt_reg[1] : in_reg.in_ty;
    assign tv[2] = tr ? pt_reg[2] : in_reg.in_tz;

    // Rounded product shifts.
    assign rq_q = (prod + RND_Q) >>> QUAT_FRAC_BITS;
    assign rq_o = (prod + RND_OUT) >>> OUT_SHIFT;

    // Hamilton product term order: four terms per output component.
    always_comb begin
        case (idx_reg[3:0])
            4'd0:    begin ham_a = 2'd0; ham_b = 2'd0; end
            4'd1:    begin ham_a = 2'd1; ham_b = 2'd1; end
            4'd2:    begin ham_a = 2'd2; ham_b = 2'd2; end
            4'd3:    begin ham_a = 2'd3; ham_b = 2'd3; end
            4'd4:    begin ham_a = 2'd0; ham_b = 2'd1; end
            4'd5:    begin ham_a = 2'd1; ham_b = 2'd0; end
            4'd6:    begin ham_a = 2'd2; ham_b = 2'd3; end
            4'd7:    begin ham_a = 2'd3; ham_b = 2'd2; end
            4'd8:    begin ham_a = 2'd0; ham_b = 2'd2; end
            4'd9:    begin ham_a = 2'd1; ham_b = 2'd3; end
            4'd10:   begin ham_a = 2'd2; ham_b = 2'd0; end
            4'd11:   begin ham_a = 2'd3; ham_b = 2'd1; end
            4'd12:   begin ham_a = 2'd0; ham_b = 2'd3; end
            4'd13:   begin ham_a = 2'd1; ham_b = 2'd2; end
            4'd14:   begin ham_a = 2'd2; ham_b = 2'd1; end
            default: begin ham_a = 2'd3; ham_b = 2'd0; end
        endcase
        ham_neg = (kk == 4'd1) || (kk == 4'd2) || (kk == 4'd3) || (kk == 4'd7) ||
                  (kk == 4'd9) || (kk == 4'd14);
    end

    // Matrix-vector walk: entry index, column for issue, row for the sum.
    always_comb begin
        rot_e = (idx_reg < 5'd9) ? idx_reg[3:0] : 4'd0;
        case (idx_reg[3:0])
            4'd0, 4'd3, 4'd6: rot_col = 2'd0;
            4'd1, 4'd4, 4'd7: rot_col = 2'd1;
            default:          rot_col = 2'd2;
        endcase
        if (kk < 4'd3) begin
            rot_row = 2'd0;
        end else if (kk < 4'd6) begin
            rot_row = 2'd1;
        end else begin
            rot_row = 2'd2;
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (ph_reg)
            PH_QQ: begin
                case (idx_reg[3:0])
                    4'd0: begin op_a = MUL_W'(pq_reg[1]); op_b = MUL_W'(pq_reg[1]); end
                    4'd1: begin op_a = MUL_W'(pq_reg[2]); op_b = MUL_W'(pq_reg[2]); end
                    4'd2: begin op_a = MUL_W'(pq_reg[3]); op_b = MUL_W'(pq_reg[3]); end
                    4'd3: begin op_a = MUL_W'(pq_reg[1]); op_b = MUL_W'(pq_reg[2]); end
                    4'd4: begin op_a = MUL_W'(pq_reg[1]); op_b = MUL_W'(pq_reg[3]); end
                    4'd5: begin op_a = MUL_W'(pq_reg[2]); op_b = MUL_W'(pq_reg[3]); end
                    4'd6: begin op_a = MUL_W'(pq_reg[0]); op_b = MUL_W'(pq_reg[1]); end
                    4'd7: begin op_a = MUL_W'(pq_reg[0]); op_b = MUL_W'(pq_reg[2]); end
                    4'd8: begin op_a = MUL_W'(pq_reg[0]); op_b = MUL_W'(pq_reg[3]); end
                    default: ;
                endcase
            end
            PH_ROT: begin
                op_a = MUL_W'(ent_reg[rot_e]);
                op_b = MUL_W'(tv[rot_col]);
            end
            PH_HAM: begin
                op_a = MUL_W'(pq_reg[ham_a]);
                op_b = MUL_W'(iq[ham_b]);
            end
            PH_NSUM: begin
                op_a = MUL_W'(m_reg[idx_reg[1:0]]);
                op_b = MUL_W'(m_reg[idx_reg[1:0]]);
            end
            PH_NEWT: begin
                case (idx_reg[2:0])
                    3'd0: begin op_a = MUL_W'(y_reg); op_b = MUL_W'(y_reg); end
                    3'd2: begin op_a = MUL_W'(n_reg[62:30]); op_b = MUL_W'(t_reg); end
                    3'd4: begin op_a = MUL_W'(y_reg); op_b = MUL_W'(h_reg); end
                    default: ;
                endcase
            end
            PH_OUT: begin
                op_a = MUL_W'(m_reg[idx_reg[1:0]]);
                op_b = MUL_W'(y_reg);
            end
            default: ;
        endcase
    end

    rpci_mul u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // Clamp a rotation matrix entry to [-2^31, 2^31].
    function automatic logic signed [ENT_W-1:0] clamp_ent(input logic signed [39:0] v);
        logic signed [ENT_W-1:0] r;
        if (v > ENT_LIM) begin
            r = ENT_W'(ENT_LIM);
        end else if (v < -ENT_LIM) begin
            r = ENT_W'(-ENT_LIM);
        end else begin
            r = ENT_W'(v);
        end
        return r;
    endfunction

    // Rotation matrix from the rounded component products, transposed for invert.
    always_comb begin
        mat[0] = ONE_E - 40'sd2 * (40'(qm_reg[1]) + 40'(qm_reg[2]));
        mat[1] = 40'sd2 * (40'(qm_reg[3]) - 40'(qm_reg[8]));
        mat[2] = 40'sd2 * (40'(qm_reg[4]) + 40'(qm_reg[7]));
        mat[3] = 40'sd2 * (40'(qm_reg[3]) + 40'(qm_reg[8]));
        mat[4] = ONE_E - 40'sd2 * (40'(qm_reg[0]) + 40'(qm_reg[2]));
        mat[5] = 40'sd2 * (40'(qm_reg[5]) - 40'(qm_reg[6]));
        mat[6] = 40'sd2 * (40'(qm_reg[4]) - 40'(qm_reg[7]));
        mat[7] = 40'sd2 * (40'(qm_reg[5]) + 40'(qm_reg[6]));
        mat[8] = ONE_E - 40'sd2 * (40'(qm_reg[0]) + 40'(qm_reg[1]));
        ent_next[0] = clamp_ent(mat[0]);
        ent_next[1] = clamp_ent(tr ? mat[3] : mat[1]);
        ent_next[2] = clamp_ent(tr ? mat[6] : mat[2]);
        ent_next[3] = clamp_ent(tr ? mat[1] : mat[3]);
        ent_next[4] = clamp_ent(mat[4]);
        ent_next[5] = clamp_ent(tr ? mat[7] : mat[5]);
        ent_next[6] = clamp_ent(tr ? mat[2] : mat[6]);
        ent_next[7] = clamp_ent(tr ? mat[5] : mat[7]);
        ent_next[8] = clamp_ent(mat[8]);
    end

    // Translation update: add the old translation, or negate for invert.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (tr) begin
                tup_s[i] = sat32(-prod_t'(r_reg[i]));
            end else begin
                tup_s[i] = sat32(prod_t'(r_reg[i]) + prod_t'(pt_reg[i]));
            end
        end
    end

    // Normalization helpers: magnitude, bit-length search, scaling, seed.
    always_comb begin
        cur_c    = c_reg[idx_reg[1:0]];
        mag      = cur_c[63] ? MAG_W'(-cur_c) : MAG_W'(cur_c);
        len_base = (idx_reg == 5'd0) ? '0 : len_reg;
        len_cand = len_base + (LEN_W'(1) << (3'd5 - idx_reg[2:0]));
        len_hit  = (amax_reg >> len_cand) != '0;
        if (len_reg >= LEN_W'(30)) begin
            sc_m = 32'(cur_c >>> (len_reg - LEN_W'(29)));
        end else begin
            sc_m = 32'(cur_c <<< (LEN_W'(29) - len_reg));
        end
        n_small  = (n_reg[63:60] == 4'd0);
        nn       = n_small ? (n_reg << 2) : n_reg;
        seed_idx = 4'(5'(nn[62:58]) - 5'd4);
        xyy      = prod[63:30];
        out_s    = sat32(rq_o);
    end

    // Sequencer and datapath registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg      <= PH_IDLE;
            idx_reg     <= '0;
            iter_reg    <= '0;
            act_reg     <= ACT_HOLD;
            clip_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            pq_reg[0]   <= ONE_Q;
            pq_reg[1]   <= '0;
            pq_reg[2]   <= '0;
            pq_reg[3]   <= '0;
            pt_reg[0]   <= '0;
            pt_reg[1]   <= '0;
            pt_reg[2]   <= '0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (ph_reg)
                PH_IDLE: begin
                    if (s_fire) begin
                        in_reg   <= s_data;
                        act_reg  <= s_data.action;
                        clip_reg <= 1'b0;
                        idx_reg  <= '0;
                        iter_reg <= '0;
                        case (s_data.action)
                            ACT_LOAD: begin
                                pt_reg[0] <= s_data.in_tx;
                                pt_reg[1] <= s_data.in_ty;
                                pt_reg[2] <= s_data.in_tz;
                                c_reg[0]  <= 64'(s_data.in_qw);
                                c_reg[1]  <= 64'(s_data.in_qx);
                                c_reg[2]  <= 64'(s_data.in_qy);
                                c_reg[3]  <= 64'(s_data.in_qz);
                                ph_reg    <= PH_AMAX;
                            end
                            ACT_COMPOSE, ACT_INVERT: begin
                                ph_reg <= PH_QQ;
                            end
                            default: begin
                                ph_reg <= PH_DONE;
                            end
                        endcase
                    end
                end
                // Nine rounded component products for the rotation matrix.
                PH_QQ: begin
                    if (idx_reg != 5'd0) begin
                        qm_reg[kk] <= QM_W'(rq_q);
                    end
                    if (idx_reg == 5'd9) begin
                        idx_reg <= '0;
                        ph_reg  <= PH_MAT;
                    end else begin
                        idx_reg <= idx_reg + 5'd1;
                    end
                end
                PH_MAT: begin
                    for (int k = 0; k < 9; k++) begin
                        ent_reg[k] <= ent_next[k];
                    end
                    for (int i = 0; i < 3; i++) begin
                        r_reg[i] <= '0;
                    end
                    ph_reg <= PH_ROT;
                end
                // Matrix times translation, one term per cycle.
                PH_ROT: begin
                    if (idx_reg != 5'd0) begin
                        r_reg[rot_row] <= r_reg[rot_row] + R_W'(rq_q);
                    end
                    if (idx_reg == 5'd9) begin
                        idx_reg <= '0;
                        ph_reg  <= PH_TUP;
                    end else begin
                        idx_reg <= idx_reg + 5'd1;
                    end
                end
                PH_TUP: begin
                    for (int i = 0; i < 3; i++) begin
                        pt_reg[i] <= tup_s[i].val;
                    end
                    clip_reg <= tup_s[0].clip | tup_s[1].clip | tup_s[2].clip;
                    if (tr) begin
                        c_reg[0] <= 64'(pq_reg[0]);
                        c_reg[1] <= -64'(pq_reg[1]);
                        c_reg[2] <= -64'(pq_reg[2]);
                        c_reg[3] <= -64'(pq_reg[3]);
                        ph_reg   <= PH_AMAX;
                    end else begin
                        ph_reg <= PH_HAM;
                    end
                end
                // Hamilton product, each term floored by four.
                PH_HAM: begin
                    if (idx_reg != 5'd0) begin
                        if (ham_neg) begin
                            c_reg[kk[3:2]] <= ((kk[1:0] == 2'd0) ? 64'sd0 : c_reg[kk[3:2]])
                                              - 64'(prod >>> 2);
                        end else begin
                            c_reg[kk[3:2]] <= ((kk[1:0] == 2'd0) ? 64'sd0 : c_reg[kk[3:2]])
                                              + 64'(prod >>> 2);
                        end
                    end
                    if (idx_reg == 5'd16) begin
                        idx_reg <= '0;
                        ph_reg  <= PH_AMAX;
                    end else begin
                        idx_reg <= idx_reg + 5'd1;
                    end
                end
                // Largest magnitude; an all-zero quaternion becomes the identity.
                PH_AMAX: begin
                    if (idx_reg == 5'd4) begin
                        idx_reg <= '0;
                        if (amax_reg == '0) begin
                            pq_reg[0] <= ONE_Q;
                            pq_reg[1] <= '0;
                            pq_reg[2] <= '0;
                            pq_reg[3] <= '0;
                            ph_reg    <= PH_DONE;
                        end else begin
                            ph_reg <= PH_LEN;
                        end
                    end else begin
                        if ((idx_reg == 5'd0) || (mag > amax_reg)) begin
                            amax_reg <= mag;
                        end
                        idx_reg <= idx_reg + 5'd1;
                    end
                end
                // Binary search for the top set bit of the largest magnitude.
                PH_LEN: begin
                    len_reg <= len_hit ? len_cand : len_base;
                    if (idx_reg == 5'd5) begin
                        idx_reg <= '0;
                        ph_reg  <= PH_SCALE;
                    end else begin
                        idx_reg <= idx_reg + 5'd1;
                    end
                end
                PH_SCALE: begin
                    m_reg[idx_reg[1:0]] <= sc_m;
                    if (idx_reg == 5'd3) begin
                        idx_reg <= '0;
                        ph_reg  <= PH_NSUM;
                    end else begin
                        idx_reg <= idx_reg + 5'd1;
                    end
                end
                // Sum of squares of the scaled components.
                PH_NSUM: begin
                    if (idx_reg != 5'd0) begin
                        n_reg <= ((idx_reg == 5'd1) ? 64'd0 : n_reg) + 64'(prod);
                    end
                    if (idx_reg == 5'd4) begin
                        idx_reg <= '0;
                        ph_reg  <= PH_DBL;
                    end else begin
                        idx_reg <= idx_reg + 5'd1;
                    end
                end
                PH_DBL: begin
                    n_reg <= nn;
                    if (n_small) begin
                        for (int i = 0; i < 4; i++) begin
                            m_reg[i] <= m_reg[i] <<< 1;
                        end
                    end
                    y_reg    <= Y_W'(rsqrt_seed(seed_idx)) << 14;
                    iter_reg <= '0;
                    idx_reg  <= '0;
                    ph_reg   <= PH_NEWT;
                end
                // Newton step y = y*(3 - x*y*y)/2: square y, times x, subtract from three, times y.
                PH_NEWT: begin
                    case (idx_reg[2:0])
                        3'd1: t_reg <= prod[63:30];
                        3'd3: h_reg <= (xyy > THREE_Q30) ? 32'd0 : 32'(THREE_Q30 - xyy);
                        3'd5: y_reg <= prod[64:31];
                        default: ;
                    endcase
                    if (idx_reg == 5'd5) begin
                        idx_reg <= '0;
                        if (iter_reg == 3'(RSQRT_ITERATIONS - 1)) begin
                            ph_reg <= PH_OUT;
                        end else begin
                            iter_reg <= iter_reg + 3'd1;
                        end
                    end else begin
                        idx_reg <= idx_reg + 5'd1;
                    end
                end
                PH_OUT: begin
                    if (idx_reg != 5'd0) begin
                        pq_reg[kk[1:0]] <= out_s.val;
                    end
                    if (idx_reg == 5'd4) begin
                        idx_reg <= '0;
                        ph_reg  <= PH_DONE;
                    end else begin
                        idx_reg <= idx_reg + 5'd1;
                    end
                end
                // Hand the pose to the output register once it is free.
                PH_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg.out_qw    <= pq_reg[0];
                        m_data_reg.out_qx    <= pq_reg[1];
                        m_data_reg.out_qy    <= pq_reg[2];
                        m_data_reg.out_qz    <= pq_reg[3];
                        m_data_reg.out_tx    <= pt_reg[0];
                        m_data_reg.out_ty    <= pt_reg[1];
                        m_data_reg.out_tz    <= pt_reg[2];
                        m_data_reg.saturated <= clip_reg;
                        m_valid_reg          <= 1'b1;
                        ph_reg               <= PH_IDLE;
                    end
                end
                default: begin
                    ph_reg <= PH_IDLE;
                end
            endcase
        end
    end

    `RPCI_ASSERT_ALWAYS(a_reset_state, aclk, !aresetn |=> (!m_valid && s_ready), "reset did not clear the block")
    `RPCI_ASSERT(a_busy_after_accept, aclk, aresetn, s_fire |=> !s_ready, "word accepted while busy")
    `RPCI_ASSERT(a_result_from_done, aclk, aresetn, $rose(m_valid_reg) |-> $past(ph_reg == PH_DONE), "result raised outside the final phase")
    `RPCI_ASSERT(a_norm_range, aclk, aresetn, (ph_reg == PH_NEWT) |-> (n_reg[63] == 1'b0 && n_reg[62:60] != 3'b000), "sum of squares out of the seed range")
    `RPCI_ASSERT(a_clip_source, aclk, aresetn, ($rose(m_valid_reg) && m_data_reg.saturated) |-> (act_reg == ACT_COMPOSE || act_reg == ACT_INVERT), "clip flag on load or hold")

endmodule

// File: test/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the rigid pose block: load, compose, invert and hold.
// ---------------------------------------------------------------------------
// A predictor in this file tracks the stored pose and works out each result
// word. A short table of directed words runs first, then random words in
// several idling phases. Results are compared field by field, in order.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rpci_pkg::*;

    localparam int QF = QUAT_FRAC_BITS;
    localparam logic signed [31:0] Q_ONE = 32'sd1 << QF;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    rigid_pose_compose_invert u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Predicted pose state.
    logic signed [31:0] cur_q [4];
    logic signed [31:0] cur_t [3];

    out_word_t pose_queue [$];
    int        errors = 0;
    int        send_idle = 0;
    int        recv_stall = 0;

    // Start values of the inverse square root, Q16.
    localparam logic [15:0] SEED [13] = '{61788, 55889, 51411, 47861, 44957, 42525,
        40450, 38651, 37073, 35673, 34421, 33292, 32768};

    function automatic longint rshift_rnd(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [31:0] clip32(longint v, ref bit clip);
        if (v > 64'sd2147483647) begin
            clip = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            clip = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Renormalize four wide components into the stored quaternion.
    function automatic void renorm(longint c[4]);
        longint unsigned amax, mag, y, t, xyy, h, three;
        longint m[4];
        longint n;
        int len;
        bit junk;
        amax = 0;
        n = 0;
        len = 0;
        junk = 1'b0;
        for (int i = 0; i < 4; i++) begin
            mag = c[i] < 0 ? -c[i] : c[i];
            if (mag > amax) amax = mag;
        end
        if (amax == 0) begin
            cur_q[0] = Q_ONE;
            cur_q[1] = 0; cur_q[2] = 0; cur_q[3] = 0;
            return;
        end
        while (len < 63 && (amax >> len) != 0) len++;
        for (int i = 0; i < 4; i++) begin
            m[i] = len > 30 ? (c[i] >>> (len - 30)) : (c[i] <<< (30 - len));
            n += m[i] * m[i];
        end
        if (n < (64'sd1 <<< 60)) begin
            for (int i = 0; i < 4; i++) m[i] *= 2;
            n *= 4;
        end
        y = longint'(SEED[(longint'(unsigned'(n)) >> 58) - 4]) << 14;
        three = 64'd3 << 30;
        for (int k = 0; k < RSQRT_ITERATIONS; k++) begin
            t = (y * y) >> 30;
            xyy = ((longint'(unsigned'(n)) >> 30) * t) >> 30;
            h = xyy > three ? 0 : three - xyy;
            y = (y * h) >> 31;
        end
        for (int i = 0; i < 4; i++)
            cur_q[i] = clip32(rshift_rnd(m[i] * longint'(y), 60 - QF), junk);
    endfunction

    // Rotate t by the stored quaternion, or by its transpose.
    function automatic void rotate_vec(longint t[3], bit transp, output longint r[3]);
        longint one, xx, yy, zz, xy, xz, yz, wx, wy, wz, e;
        longint mat[3][3];
        one = 64'sd1 <<< QF;
        xx = rshift_rnd(longint'(cur_q[1]) * cur_q[1], QF);
        yy = rshift_rnd(longint'(cur_q[2]) * cur_q[2], QF);
        zz = rshift_rnd(longint'(cur_q[3]) * cur_q[3], QF);
        xy = rshift_rnd(longint'(cur_q[1]) * cur_q[2], QF);
        xz = rshift_rnd(longint'(cur_q[1]) * cur_q[3], QF);
        yz = rshift_rnd(longint'(cur_q[2]) * cur_q[3], QF);
        wx = rshift_rnd(longint'(cur_q[0]) * cur_q[1], QF);
        wy = rshift_rnd(longint'(cur_q[0]) * cur_q[2], QF);
        wz = rshift_rnd(longint'(cur_q[0]) * cur_q[3], QF);
        mat[0][0] = one - 2 * (yy + zz); mat[0][1] = 2 * (xy - wz); mat[0][2] = 2 * (xz + wy);
        mat[1][0] = 2 * (xy + wz); mat[1][1] = one - 2 * (xx + zz); mat[1][2] = 2 * (yz - wx);
        mat[2][0] = 2 * (xz - wy); mat[2][1] = 2 * (yz + wx); mat[2][2] = one - 2 * (xx + yy);
        for (int i = 0; i < 3; i++) begin
            r[i] = 0;
            for (int j = 0; j < 3; j++) begin
                e = transp ? mat[j][i] : mat[i][j];
                if (e > (64'sd1 <<< 31)) e = 64'sd1 <<< 31;
                if (e < -(64'sd1 <<< 31)) e = -(64'sd1 <<< 31);
                r[i] += rshift_rnd(e * t[j], QF);
            end
        end
    endfunction

    // Apply one action to the predicted pose and return the new pose word.
    function automatic out_word_t pose_update(in_word_t w);
        longint iq[4], it[3], c[4], r[3], a[4];
        out_word_t o;
        bit clip;
        clip = 1'b0;
        iq = '{w.in_qw, w.in_qx, w.in_qy, w.in_qz};
        it = '{w.in_tx, w.in_ty, w.in_tz};
        case (w.action)
            ACT_LOAD: begin
                renorm(iq);
                for (int i = 0; i < 3; i++) cur_t[i] = 32'(it[i]);
            end
            ACT_COMPOSE: begin
                for (int i = 0; i < 4; i++) a[i] = cur_q[i];
                rotate_vec(it, 1'b0, r);
                for (int i = 0; i < 3; i++) cur_t[i] = clip32(r[i] + cur_t[i], clip);
                c[0] = ((a[0]*iq[0]) >>> 2) - ((a[1]*iq[1]) >>> 2)
                     - ((a[2]*iq[2]) >>> 2) - ((a[3]*iq[3]) >>> 2);
                c[1] = ((a[0]*iq[1]) >>> 2) + ((a[1]*iq[0]) >>> 2)
                     + ((a[2]*iq[3]) >>> 2) - ((a[3]*iq[2]) >>> 2);
                c[2] = ((a[0]*iq[2]) >>> 2) - ((a[1]*iq[3]) >>> 2)
                     + ((a[2]*iq[0]) >>> 2) + ((a[3]*iq[1]) >>> 2);
                c[3] = ((a[0]*iq[3]) >>> 2) + ((a[1]*iq[2]) >>> 2)
                     - ((a[2]*iq[1]) >>> 2) + ((a[3]*iq[0]) >>> 2);
                renorm(c);
            end
            ACT_INVERT: begin
                for (int i = 0; i < 3; i++) it[i] = cur_t[i];
                rotate_vec(it, 1'b1, r);
                for (int i = 0; i < 3; i++) cur_t[i] = clip32(-r[i], clip);
                c = '{cur_q[0], -longint'(cur_q[1]), -longint'(cur_q[2]),
                      -longint'(cur_q[3])};
                renorm(c);
            end
            default: ;
        endcase
        o.out_qw = cur_q[0]; o.out_qx = cur_q[1];
        o.out_qy = cur_q[2]; o.out_qz = cur_q[3];
        o.out_tx = cur_t[0]; o.out_ty = cur_t[1]; o.out_tz = cur_t[2];
        o.saturated = clip;
        return o;
    endfunction

    // Directed table; a row with a typed-in result checks that too.
    typedef struct {
        in_word_t  w;
        bit        fixed;
        out_word_t res;
    } row_t;

    function automatic in_word_t mk(logic [1:0] a, int qw, int qx, int qy, int qz,
                                    int tx, int ty, int tz);
        in_word_t w;
        w.action = a;
        w.in_qw = qw; w.in_qx = qx; w.in_qy = qy; w.in_qz = qz;
        w.in_tx = tx; w.in_ty = ty; w.in_tz = tz;
        return w;
    endfunction

    function automatic out_word_t mo(int qw, int qx, int qy, int qz,
                                     int tx, int ty, int tz, bit s);
        out_word_t o;
        o.out_qw = qw; o.out_qx = qx; o.out_qy = qy; o.out_qz = qz;
        o.out_tx = tx; o.out_ty = ty; o.out_tz = tz; o.saturated = s;
        return o;
    endfunction

    localparam int MX = 32'h7fffffff;
    localparam int MN = 32'h80000000;

    row_t dir_rows [$];

    task automatic build_table();
        // Hold right after reset shows the identity pose.
        dir_rows.push_back('{mk(ACT_HOLD, 5, 6, 7, 8, 9, 10, 11), 1, mo(Q_ONE, 0, 0, 0, 0, 0, 0, 0)});
        // Zero quaternion load gives identity, translation taken as given.
        dir_rows.push_back('{mk(ACT_LOAD, 0, 0, 0, 0, MX, MN, 1), 1, mo(Q_ONE, 0, 0, 0, MX, MN, 1, 0)});
        dir_rows.push_back('{mk(ACT_COMPOSE, Q_ONE, 0, 0, 0, MX, MX, MN), 0, '0});
        dir_rows.push_back('{mk(ACT_LOAD, Q_ONE, 0, 0, 0, MX, MX, MX), 0, '0});
        dir_rows.push_back('{mk(ACT_COMPOSE, Q_ONE, 0, 0, 0, MX, MX, MX), 0, '0});
        dir_rows.push_back('{mk(ACT_INVERT, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        dir_rows.push_back('{mk(ACT_LOAD, MN, MN, MN, MN, MN, MN, MN), 0, '0});
        dir_rows.push_back('{mk(ACT_INVERT, -1, -1, -1, -1, -1, -1, -1), 0, '0});
        dir_rows.push_back('{mk(ACT_LOAD, MX, MX, MX, MX, 0, 0, 0), 0, '0});
        dir_rows.push_back('{mk(ACT_COMPOSE, MN, MX, MN, MX, MN, MN, MN), 0, '0});
        dir_rows.push_back('{mk(ACT_LOAD, 1, 0, 0, 0, 65536, -65536, 3), 0, '0});
        dir_rows.push_back('{mk(ACT_LOAD, 0, 0, 0, -1, 0, 0, 0), 0, '0});
        dir_rows.push_back('{mk(ACT_COMPOSE, 0, 0, 0, 0, 100, 200, 300), 0, '0});
        dir_rows.push_back('{mk(ACT_LOAD, 0, Q_ONE, 0, 0, 1000, 2000, 3000), 0, '0});
        dir_rows.push_back('{mk(ACT_COMPOSE, 0, 0, Q_ONE, 0, 5, -5, 7), 0, '0});
        dir_rows.push_back('{mk(ACT_INVERT, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        dir_rows.push_back('{mk(ACT_HOLD, MN, MX, MN, MX, MN, MX, MN), 0, '0});
        dir_rows.push_back('{mk(ACT_LOAD, 12345, -54321, 777, 1, MN, MN, MN), 0, '0});
        dir_rows.push_back('{mk(ACT_INVERT, 0, 0, 0, 0, 0, 0, 0), 0, '0});
    endtask

    function automatic int rnd32();
        return int'($urandom);
    endfunction

    // Random word: mostly scaled-down values with holds made composes, with raw noise mixed in.
    function automatic in_word_t rand_word();
        in_word_t w;
        int k;
        k = $urandom_range(0, 99);
        w = mk(2'($urandom_range(0, 3)), rnd32(), rnd32(), rnd32(), rnd32(),
               rnd32(), rnd32(), rnd32());
        if (k < 75) begin
            if (w.action == ACT_HOLD) w.action = ACT_COMPOSE;
            w.in_qw = $signed(w.in_qw) >>> $urandom_range(0, 31);
            w.in_qx = $signed(w.in_qx) >>> $urandom_range(0, 31);
            w.in_qy = $signed(w.in_qy) >>> $urandom_range(0, 31);
            w.in_qz = $signed(w.in_qz) >>> $urandom_range(0, 31);
            w.in_tx = $signed(w.in_tx) >>> $urandom_range(0, 24);
            w.in_ty = $signed(w.in_ty) >>> $urandom_range(0, 24);
            w.in_tz = $signed(w.in_tz) >>> $urandom_range(0, 24);
        end
        return w;
    endfunction

    out_word_t fixed_queue [$];
    bit        fixed_flag [$];

    // Offer one word and wait for its acceptance. Valid drops only while the
    // sender idles, so a word may follow its predecessor at the same edge.
    task automatic send_word(in_word_t w, bit fixed, out_word_t res);
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        pose_queue.push_back(pose_update(w));
        fixed_flag.push_back(fixed);
        fixed_queue.push_back(res);
    endtask

    // Receiver stalls and result check.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pose_queue.size() == 0) begin
                    $error("result word with nothing expected");
                    errors++;
                end else begin
                    out_word_t e, fx;
                    bit f;
                    e = pose_queue.pop_front();
                    fx = fixed_queue.pop_front();
                    f = fixed_flag.pop_front();
                    if (f && fx != e) begin
                        $error("predictor disagrees with table: exp %h got %h", fx, e);
                        errors++;
                    end
                    if (m_data.out_qw !== e.out_qw) begin
                        $error("out_qw exp %0d got %0d", e.out_qw, m_data.out_qw); errors++;
                    end
                    if (m_data.out_qx !== e.out_qx) begin
                        $error("out_qx exp %0d got %0d", e.out_qx, m_data.out_qx); errors++;
                    end
                    if (m_data.out_qy !== e.out_qy) begin
                        $error("out_qy exp %0d got %0d", e.out_qy, m_data.out_qy); errors++;
                    end
                    if (m_data.out_qz !== e.out_qz) begin
                        $error("out_qz exp %0d got %0d", e.out_qz, m_data.out_qz); errors++;
                    end
                    if (m_data.out_tx !== e.out_tx) begin
                        $error("out_tx exp %0d got %0d", e.out_tx, m_data.out_tx); errors++;
                    end
                    if (m_data.out_ty !== e.out_ty) begin
                        $error("out_ty exp %0d got %0d", e.out_ty, m_data.out_ty); errors++;
                    end
                    if (m_data.out_tz !== e.out_tz) begin
                        $error("out_tz exp %0d got %0d", e.out_tz, m_data.out_tz); errors++;
                    end
                    if (m_data.saturated !== e.saturated) begin
                        $error("saturated exp %0b got %0b", e.saturated, m_data.saturated);
                        errors++;
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    // Stimulus.
    initial begin
        cur_q = '{Q_ONE, 0, 0, 0};
        cur_t = '{0, 0, 0};
        build_table();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].fixed, dir_rows[i].res);
        for (int ph = 0; ph < 4; ph++) begin
            send_idle  = (ph == 1 || ph == 3) ? (ph == 1 ? 73 : 22) : 0;
            recv_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 73 : 22) : 0;
            for (int i = 0; i < 100; i++) begin
                send_word(rand_word(), 1'b0, '0);
                // Hold off once until every pending pose has come back.
                if (ph == 0 && i == 50) begin
                    s_valid <= 1'b0;
                    while (pose_queue.size() != 0) @(posedge aclk);
                end
            end
        end
        s_valid <= 1'b0;
        while (pose_queue.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (errors == 0)
            $display("rigid_pose_compose_invert verification clean");
        else
            $display("rigid_pose_compose_invert verification failed");
        $finish;
    end

    // Watchdog.
    initial begin
        #20ms;
        $display("rigid_pose_compose_invert verification failed");
        $finish;
    end

endmodule
